// File: sv/wds_pkg.sv
`default_nettype none

package wds_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ACT_W     = 2;
    localparam int VAL_W     = 32;
    localparam int WT_W      = 16;
    localparam int SEL_W     = 32;
    localparam int SUM_W     = 24;
    localparam int ST_W      = 2;
    localparam int OUT_IDX_W = 8;
    localparam int OUT_CNT_W = 9;
    localparam int TGT_W     = SEL_W + SUM_W;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL       = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY      = 2'd2;
    localparam logic [ST_W-1:0] ST_ZERO_TOTAL = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_THR,
        S_PROBE,
        S_CMP,
        S_FETCH,
        S_PICK,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic            capture;
        logic            clear;
        logic            load;
        logic            set_status;
        logic [ST_W-1:0] status;
        logic            mul;
        logic            thr;
        logic            probe;
        logic            update;
        logic            fetch;
        logic            pick;
        logic            out_load;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             full;
        logic             empty;
        logic             zero_total;
        logic             search_done;
    } t_sts;

endpackage

`default_nettype wire

// File: sv/wds_ctrl.sv
`default_nettype none

module wds_ctrl
    import wds_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RESULT;
                priority if (i_sts.action == ACT_CLEAR) begin
                    cmd.clear = 1'b1;
                end else if (i_sts.action == ACT_LOAD) begin
                    if (i_sts.full) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_FULL;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end else if (i_sts.action == ACT_SAMPLE) begin
                    if (i_sts.empty) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_EMPTY;
                    end else if (i_sts.zero_total) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_ZERO_TOTAL;
                    end else begin
                        cmd.mul = 1'b1;
                        n_state = S_THR;
                    end
                end else begin
                    // unused code: report the table summary only
                    n_state = S_RESULT;
                end
            end
            S_THR: begin
                cmd.thr = 1'b1;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (i_sts.search_done) begin
                    cmd.fetch = 1'b1;
                    n_state   = S_FETCH;
                end else begin
                    cmd.probe = 1'b1;
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                cmd.update = 1'b1;
                n_state    = S_PROBE;
            end
            S_FETCH: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                cmd.pick = 1'b1;
                n_state  = S_RESULT;
            end
            S_RESULT: begin
                if (!r_valid || !i_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (cmd.out_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

// File: sv/wds_dp.sv
`default_nettype none

module wds_dp
    import wds_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_wdata,
    input  wire logic [ACT_W-1:0]        i_action,
    input  wire logic signed [VAL_W-1:0] i_entry_value,
    input  wire logic [WT_W-1:0]         i_entry_weight,
    input  wire logic [SEL_W-1:0]        i_selector,
    input  wire t_cmd                    i_cmd,
    output t_sts                         o_sts,
    output logic [ST_W-1:0]              o_status,
    output logic signed [VAL_W-1:0]      o_sample_value,
    output logic [OUT_IDX_W-1:0]         o_sample_index,
    output logic [OUT_CNT_W-1:0]         o_entry_count,
    output logic [SUM_W-1:0]             o_total_weight,
    output logic signed [VAL_W-1:0]      o_smallest_value,
    output logic signed [VAL_W-1:0]      o_largest_value
);

    logic [VAL_W-1:0] mem_val [TABLE_DEPTH];
    logic [SUM_W-1:0] mem_cum [TABLE_DEPTH];

    logic                    r_uniform;
    logic [ACT_W-1:0]        r_action;
    logic signed [VAL_W-1:0] r_value;
    logic [WT_W-1:0]         r_weight;
    logic [SEL_W-1:0]        r_selector;

    logic [CNT_W-1:0]        r_count;
    logic [SUM_W-1:0]        r_sum;
    logic signed [VAL_W-1:0] r_min;
    logic signed [VAL_W-1:0] r_max;

    logic [TGT_W-1:0]        r_target;
    logic [SUM_W:0]          r_thr;
    logic [CNT_W-1:0]        r_lo;
    logic [CNT_W-1:0]        r_hi;
    logic [CNT_W-1:0]        r_mid;
    logic [SUM_W-1:0]        r_rd_cum;
    logic [VAL_W-1:0]        r_rd_val;
    logic [IDX_W-1:0]        r_fetch_idx;

    logic [ST_W-1:0]         r_status;
    logic signed [VAL_W-1:0] r_pick_value;
    logic [IDX_W-1:0]        r_pick_index;

    logic [ST_W-1:0]         r_o_status;
    logic signed [VAL_W-1:0] r_o_sample_value;
    logic [OUT_IDX_W-1:0]    r_o_sample_index;
    logic [OUT_CNT_W-1:0]    r_o_entry_count;
    logic [SUM_W-1:0]        r_o_total_weight;
    logic signed [VAL_W-1:0] r_o_smallest_value;
    logic signed [VAL_W-1:0] r_o_largest_value;

    logic [SUM_W-1:0] n_w;
    logic [SUM_W:0]   n_add;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W:0]   n_mid_sum;
    logic [CNT_W-1:0] n_mid;
    logic [CNT_W-1:0] n_last;
    logic [CNT_W-1:0] n_pick;

    assign n_w   = r_uniform ? SUM_W'(1) : SUM_W'(r_weight);
    assign n_add = {1'b0, r_sum} + {1'b0, n_w};
    assign n_sum = n_add[SUM_W] ? SUM_MAX : n_add[SUM_W-1:0];

    assign n_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign n_mid     = n_mid_sum[CNT_W:1];
    assign n_last    = r_count - CNT_W'(1);
    // lower bound ran off the end: clamp to the last entry
    assign n_pick    = (r_lo == r_count) ? n_last : r_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uniform <= 1'b0;
        end else if (i_cfg_we) begin
            r_uniform <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_min   <= '0;
            r_max   <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_sum   <= '0;
            r_min   <= '0;
            r_max   <= '0;
        end else if (i_cmd.load) begin
            r_count <= r_count + CNT_W'(1);
            r_sum   <= n_sum;
            if (r_count == '0) begin
                r_min <= r_value;
                r_max <= r_value;
            end else begin
                if (r_value < r_min) begin
                    r_min <= r_value;
                end
                if (r_value > r_max) begin
                    r_max <= r_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem_val[r_count[IDX_W-1:0]] <= r_value;
        end
        if (i_cmd.fetch) begin
            r_rd_val <= mem_val[n_pick[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem_cum[r_count[IDX_W-1:0]] <= n_sum;
        end
        if (i_cmd.probe) begin
            r_rd_cum <= mem_cum[n_mid[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action     <= i_action;
            r_value      <= i_entry_value;
            r_weight     <= i_entry_weight;
            r_selector   <= i_selector;
            r_status     <= ST_OK;
            r_pick_value <= '0;
            r_pick_index <= '0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.mul) begin
            r_target <= TGT_W'(r_selector) * TGT_W'(r_sum);
            r_lo     <= '0;
            r_hi     <= r_count;
        end
        if (i_cmd.thr) begin
            // c<<32 >= u*T  <=>  c >= ceil(u*T / 2^32)
            r_thr <= {1'b0, r_target[TGT_W-1:SEL_W]} + (SUM_W+1)'(|r_target[SEL_W-1:0]);
        end
        if (i_cmd.probe) begin
            r_mid <= n_mid;
        end
        if (i_cmd.update) begin
            if ({1'b0, r_rd_cum} >= r_thr) begin
                r_hi <= r_mid;
            end else begin
                r_lo <= r_mid + CNT_W'(1);
            end
        end
        if (i_cmd.fetch) begin
            r_fetch_idx <= n_pick[IDX_W-1:0];
        end
        if (i_cmd.pick) begin
            r_pick_value <= r_rd_val;
            r_pick_index <= r_fetch_idx;
        end
        if (i_cmd.out_load) begin
            r_o_status         <= r_status;
            r_o_sample_value   <= r_pick_value;
            r_o_sample_index   <= OUT_IDX_W'(r_pick_index);
            r_o_entry_count    <= OUT_CNT_W'(r_count);
            r_o_total_weight   <= r_sum;
            r_o_smallest_value <= r_min;
            r_o_largest_value  <= r_max;
        end
    end

    assign o_sts.action      = r_action;
    assign o_sts.full        = (r_count == CNT_W'(TABLE_DEPTH));
    assign o_sts.empty       = (r_count == '0);
    assign o_sts.zero_total  = (r_sum == '0);
    assign o_sts.search_done = (r_lo == r_hi);

    assign o_status         = r_o_status;
    assign o_sample_value   = r_o_sample_value;
    assign o_sample_index   = r_o_sample_index;
    assign o_entry_count    = r_o_entry_count;
    assign o_total_weight   = r_o_total_weight;
    assign o_smallest_value = r_o_smallest_value;
    assign o_largest_value  = r_o_largest_value;

endmodule

`default_nettype wire

// File: sv/weighted_discrete_sampler_core.sv
// Accept to result valid: clear, load and the unused code pass IDLE, DECODE, RESULT.
// A sample runs DECODE, THR, p PROBE/CMP rounds, a final PROBE, FETCH, PICK, RESULT,
// with p <= ceil(log2(count+1)) lower-bound probes (p <= 9 at 256). One word in
// flight at a time; the next word is taken the cycle after the result is loaded;
// a stalled result holds the next one until it drains.
// Reset (sync, active low) empties the table, clears uniform mode, drops o_valid.
`default_nettype none

module weighted_discrete_sampler_core
    import wds_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_wdata,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [ACT_W-1:0]        i_action,
    input  wire logic signed [VAL_W-1:0] i_entry_value,
    input  wire logic [WT_W-1:0]         i_entry_weight,
    input  wire logic [SEL_W-1:0]        i_selector,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [ST_W-1:0]              o_status,
    output logic signed [VAL_W-1:0]      o_sample_value,
    output logic [OUT_IDX_W-1:0]         o_sample_index,
    output logic [OUT_CNT_W-1:0]         o_entry_count,
    output logic [SUM_W-1:0]             o_total_weight,
    output logic signed [VAL_W-1:0]      o_smallest_value,
    output logic signed [VAL_W-1:0]      o_largest_value
);

    t_cmd cmd;
    t_sts sts;

    wds_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    wds_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_action         (i_action),
        .i_entry_value    (i_entry_value),
        .i_entry_weight   (i_entry_weight),
        .i_selector       (i_selector),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_status         (o_status),
        .o_sample_value   (o_sample_value),
        .o_sample_index   (o_sample_index),
        .o_entry_count    (o_entry_count),
        .o_total_weight   (o_total_weight),
        .o_smallest_value (o_smallest_value),
        .o_largest_value  (o_largest_value)
    );

endmodule

`default_nettype wire

// File: sv/wds_checker.sv
`default_nettype none

module wds_checker
    import wds_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_valid,
    input wire logic                    o_stall,
    input wire logic                    o_valid,
    input wire logic                    i_stall,
    input wire logic [ST_W-1:0]         o_status,
    input wire logic signed [VAL_W-1:0] o_sample_value,
    input wire logic [OUT_IDX_W-1:0]    o_sample_index,
    input wire logic [OUT_CNT_W-1:0]    o_entry_count,
    input wire logic [SUM_W-1:0]        o_total_weight,
    input wire logic signed [VAL_W-1:0] o_smallest_value
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_sample_value))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second word taken while one is in work");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_sample_value == '0 && o_sample_index == '0)
        else $error("failed result carries a sample");

    a_empty_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_entry_count == '0 |-> o_total_weight == '0 && o_smallest_value == '0)
        else $error("empty table reports weight or value");

endmodule

bind weighted_discrete_sampler_core wds_checker u_wds_checker (.*);

`default_nettype wire
